// ===== sv/civ_asr_pkg.sv =====
// ----------------------------------------------------------------------------
// CI-V antenna switch responder package
// Byte codes, register indexes and reset values shared by the responder.
// ----------------------------------------------------------------------------
package civ_asr_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CfgOwnAddr = 2'd0;
  localparam logic [1:0] CfgIpAddr  = 2'd1;

  // Reset values.
  localparam logic [7:0] OwnAddrReset = 8'hB4;

  // CI-V byte codes.
  localparam logic [7:0] CivPreamble  = 8'hFE;
  localparam logic [7:0] CivEnd       = 8'hFD;
  localparam logic [7:0] CivCtrlAddr  = 8'hEE;
  localparam logic [7:0] CivNak       = 8'hFA;
  localparam logic [7:0] CmdQuery     = 8'h19;
  localparam logic [7:0] CmdKind      = 8'h30;
  localparam logic [7:0] CmdPort      = 8'h31;
  localparam logic [7:0] SubIpQuery   = 8'h01;
  localparam logic [7:0] BcastAddr    = 8'h00;

  // Frame lengths in bytes.
  localparam logic [7:0] LenMin   = 8'd5;
  localparam logic [7:0] LenRead  = 8'd6;
  localparam logic [7:0] LenSet   = 8'd7;

  // Reply lengths in bytes, preamble included.
  localparam logic [3:0] RepNone  = 4'd0;
  localparam logic [3:0] RepShort = 4'd6;
  localparam logic [3:0] RepRead  = 4'd7;
  localparam logic [3:0] RepEcho  = 4'd8;
  localparam logic [3:0] RepIp    = 4'd11;

  // Highest port number (one-based) for each switch type.
  localparam logic [7:0] TopFive  = 8'd5;
  localparam logic [7:0] TopEight = 8'd8;

  typedef struct packed {
    logic [7:0] frame_len;
    logic [7:0] to_addr;
    logic [7:0] from_addr;
    logic [7:0] command;
    logic [7:0] byte_five;
    logic [7:0] byte_six;
  } frame_t;

  typedef struct packed {
    logic [3:0] reply_len;
    logic [7:0] reply_dest;
    logic [7:0] reply_src;
    logic [7:0] reply_b4;
    logic [7:0] reply_b5;
    logic [7:0] reply_b6;
    logic [7:0] reply_b7;
    logic [7:0] reply_b8;
    logic [7:0] reply_b9;
    logic [7:0] reply_b10;
    logic [2:0] port_selected;
    logic       switch_kind;
  } reply_t;

endpackage

// ===== sv/civ_antenna_switch_responder.sv =====
// ----------------------------------------------------------------------------
// CI-V antenna switch responder
// Decides whether a parsed CI-V frame is for this switch and builds the reply.
// ----------------------------------------------------------------------------
// Usage:
// Each word on the slave stream is one CI-V frame that an upstream parser has
// already split into its length and bytes 2 to 6. For every word the block
// returns exactly one word on the master stream: the reply length (0 when the
// frame gets no reply), reply bytes 2 to 10 with unused bytes zeroed, and the
// selected port and switch type as they stand after that frame.
// The frame is captured in an input register, decoded by comparators and byte
// multiplexers, and the reply lands in an output register. tvalid rises once
// the frame has passed both registers; one word is accepted every cycle as long
// as the receiver keeps taking words. Port and type registers are updated as
// a frame moves from the input register to the output register, so the next
// frame already sees the new values.
// When the receiver stalls, the reply is held and one more frame waits in the
// input register; only then does s_axis_tready_o drop.
// The configuration channel is always ready and writes the own bus address
// (index 0) or the IP address reported by the 19 01 query (index 1); the user must
// write it only while the stream is idle, the block does not enforce it. Reset empties
// both registers and restores address B4, IP 0, five-port type and the first port.
// ----------------------------------------------------------------------------
module civ_antenna_switch_responder
  import civ_asr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Frame in, fields from bit 0: frame_len, to_addr, from_addr, command,
  // byte_five, byte_six.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,
  // Reply out, fields from bit 0: reply_len, reply_dest, reply_src,
  // reply_b4 to reply_b10, port_selected, switch_kind.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // Configuration and switch state.
  logic [7:0]  own_q;
  logic [31:0] ip_q;
  logic        kind_q, kind_d;
  logic [2:0]  port_q, port_d;

  // Input stage.
  logic        s1_valid_q, s1_valid_d;
  frame_t      s1_q;
  logic        in_acc;
  logic        s1_adv;

  // Output stage.
  logic        out_valid_q, out_valid_d;
  reply_t      out_q, rep_d;

  assign cfg_ready_o = 1'b1;

  // The input register moves on whenever the output register is free or is
  // being emptied in this cycle.
  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign s1_valid_d  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

  // Frame decode and reply assembly.
  always_comb begin
    logic       bcast, mine, any_addr, rd6, ok, sub_bit, b6_end;
    logic [7:0] sub, top;
    logic [7:0] b2, b3, b4, b5, b6, b7, b8, b9, b10;
    logic [3:0] n;

    kind_d = kind_q;
    port_d = port_q;
    n   = RepNone;
    b2  = 8'h00; b3 = 8'h00; b4 = 8'h00; b5 = 8'h00; b6 = 8'h00;
    b7  = 8'h00; b8 = 8'h00; b9 = 8'h00; b10 = 8'h00;

    bcast    = (s1_q.to_addr == BcastAddr);
    mine     = (s1_q.to_addr == own_q);
    any_addr = bcast || mine;
    rd6      = (s1_q.frame_len == LenRead) && (s1_q.byte_five == CivEnd);
    sub_bit  = (s1_q.byte_five[7:1] == 7'd0);
    b6_end   = (s1_q.byte_six == CivEnd);
    ok = mine ||
         ((s1_q.command == CmdQuery) && (s1_q.frame_len >= LenRead) && sub_bit
          && any_addr) ||
         (((s1_q.command == CmdKind) || (s1_q.command == CmdPort)) && rd6
          && any_addr);
    sub = (s1_q.frame_len > LenMin) ? s1_q.byte_five : 8'h00;
    top = kind_q ? TopEight : TopFive;

    if ((s1_q.frame_len >= LenMin) &&
        !((s1_q.to_addr == own_q) && (s1_q.from_addr == own_q)) && ok) begin
      // Default echo of command and subcommand.
      n  = RepEcho;
      b2 = s1_q.from_addr; b3 = own_q; b4 = s1_q.command; b5 = sub;
      b6 = own_q; b7 = CivEnd;

      if ((s1_q.command == CmdQuery) && (sub == SubIpQuery)) begin
        n  = RepIp;
        b2 = CivCtrlAddr; b3 = own_q; b4 = CmdQuery; b5 = SubIpQuery;
        b6 = ip_q[31:24]; b7 = ip_q[23:16]; b8 = ip_q[15:8]; b9 = ip_q[7:0];
        b10 = CivEnd;
      end else if (s1_q.command == CmdKind) begin
        if (rd6 && any_addr) begin
          n  = RepRead;
          b2 = s1_q.from_addr; b3 = own_q; b4 = CmdKind; b5 = {7'd0, kind_q};
          b6 = CivEnd; b7 = 8'h00;
        end else if ((s1_q.frame_len == LenSet) && sub_bit && b6_end && mine) begin
          n      = RepRead;
          kind_d = s1_q.byte_five[0];
          b2 = s1_q.from_addr; b3 = own_q; b4 = CmdKind; b5 = s1_q.byte_five;
          b6 = CivEnd; b7 = 8'h00;
        end else if (bcast && (s1_q.frame_len == LenSet) && sub_bit && b6_end) begin
          // Type set by broadcast is refused.
          n  = RepShort;
          b2 = s1_q.from_addr; b3 = own_q; b4 = CivNak; b5 = CivEnd;
          b6 = 8'h00; b7 = 8'h00;
        end
      end else if (s1_q.command == CmdPort) begin
        if (rd6 && any_addr) begin
          n  = RepRead;
          b2 = s1_q.from_addr; b3 = own_q; b4 = CmdPort;
          b5 = {5'd0, port_q} + 8'd1;
          b6 = CivEnd; b7 = 8'h00;
        end else if ((s1_q.frame_len == LenSet) && b6_end && any_addr) begin
          if ((s1_q.byte_five != 8'h00) && (s1_q.byte_five <= top)) begin
            n      = RepRead;
            port_d = s1_q.byte_five[2:0] - 3'd1;
            b2 = s1_q.from_addr; b3 = own_q; b4 = CmdPort; b5 = s1_q.byte_five;
            b6 = CivEnd; b7 = 8'h00;
          end else begin
            // Port out of range for the current type.
            n  = RepShort;
            b2 = CivCtrlAddr; b3 = own_q; b4 = CivNak; b5 = CivEnd;
            b6 = 8'h00; b7 = 8'h00;
          end
        end
      end
    end

    rep_d.reply_len     = n;
    rep_d.reply_dest    = b2;
    rep_d.reply_src     = b3;
    rep_d.reply_b4      = b4;
    rep_d.reply_b5      = b5;
    rep_d.reply_b6      = b6;
    rep_d.reply_b7      = b7;
    rep_d.reply_b8      = b8;
    rep_d.reply_b9      = b9;
    rep_d.reply_b10     = b10;
    rep_d.port_selected = port_d;
    rep_d.switch_kind   = kind_d;
  end

  // Control state, configuration and switch state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      own_q       <= OwnAddrReset;
      ip_q        <= 32'd0;
      kind_q      <= 1'b0;
      port_q      <= 3'd0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && (cfg_index_i == CfgOwnAddr)) begin
        own_q <= cfg_data_i[7:0];
      end
      if (cfg_valid_i && (cfg_index_i == CfgIpAddr)) begin
        ip_q <= cfg_data_i;
      end
      if (s1_adv) begin
        kind_q <= kind_d;
        port_q <= port_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.frame_len <= s_axis_tdata_i[7:0];
      s1_q.to_addr   <= s_axis_tdata_i[15:8];
      s1_q.from_addr <= s_axis_tdata_i[23:16];
      s1_q.command   <= s_axis_tdata_i[31:24];
      s1_q.byte_five <= s_axis_tdata_i[39:32];
      s1_q.byte_six  <= s_axis_tdata_i[47:40];
    end
    if (s1_adv) begin
      out_q <= rep_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.switch_kind, out_q.port_selected,
                            out_q.reply_b10, out_q.reply_b9, out_q.reply_b8,
                            out_q.reply_b7, out_q.reply_b6, out_q.reply_b5,
                            out_q.reply_b4, out_q.reply_src, out_q.reply_dest,
                            out_q.reply_len};

  // The switch type only changes when a frame leaves the input register.
  a_kind_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kind_q != $past(kind_q)) |-> $past(s1_valid_q && s1_adv))
    else $error("switch type changed without a frame");

  // The selected port only changes when a frame leaves the input register.
  a_port_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (port_q != $past(port_q)) |-> $past(s1_valid_q && s1_adv))
    else $error("port changed without a frame");

  // A reply word appears only after a frame sat in the input register.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("reply without a captured frame");

  // A silent result carries no destination, source or byte 4.
  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.reply_len == RepNone)) |->
    ((out_q.reply_dest == 8'h00) && (out_q.reply_src == 8'h00) &&
     (out_q.reply_b4 == 8'h00)))
    else $error("silent result carries reply bytes");

  // Every real reply is sent from the own bus address.
  a_reply_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.reply_len != RepNone)) |-> (out_q.reply_src == own_q))
    else $error("reply source differs from own address");

endmodule

// ===== bench/tb_civ_antenna_switch_responder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CI-V antenna switch responder testbench
// Streams parsed CI-V frames into the responder and checks every reply word,
// field by field, against a built-in model of the switch, across several
// settings of the bus address and the reported IP address.
// ----------------------------------------------------------------------------
module tb_civ_antenna_switch_responder;
  import civ_asr_pkg::*;

  // A stalled run is declared dead after this many cycles with no handshake.
  // The longest legal quiet spell is the receiver hold-off below plus a drain.
  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles    = 80;
  localparam int HoldEvery     = 400;
  localparam int PhaseItems    = 250;

  // Reply word layout, lowest field first.
  localparam int FieldWidth [12] = '{4, 8, 8, 8, 8, 8, 8, 8, 8, 8, 3, 1};
  string field_name [12] = '{"reply_len", "reply_dest", "reply_src", "reply_b4",
                             "reply_b5", "reply_b6", "reply_b7", "reply_b8",
                             "reply_b9", "reply_b10", "port_selected", "switch_kind"};

  typedef struct {
    frame_t f;
    bit     typed;
    reply_t want;
  } row_t;

  // All inputs of the block start at known values.
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        s_valid   = 1'b0;
  logic [47:0] s_data    = '0;
  logic        m_ready   = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = CfgOwnAddr;
  logic [31:0] cfg_data  = '0;
  logic        s_ready;
  logic        m_valid;
  logic [79:0] m_data;
  logic        cfg_ready;

  // Model copy of the registers and the switch state.
  logic [7:0]  model_own  = OwnAddrReset;
  logic [31:0] model_ip   = '0;
  logic        model_kind = 1'b0;
  logic [2:0]  model_port = 3'd0;

  logic [79:0] pending_replies [$];
  row_t        dir_rows [$];
  int          mismatches   = 0;
  int          frames_sent  = 0;
  int          results_seen = 0;
  int          idle_cycles  = 0;

  civ_antenna_switch_responder uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #6 clk = ~clk;

  // The package structs are packed with the first field on top, while the
  // stream puts the first field in the lowest bits, so the words are built
  // here field by field.
  function automatic logic [47:0] pack_frame(input frame_t f);
    return {f.byte_six, f.byte_five, f.command, f.from_addr, f.to_addr, f.frame_len};
  endfunction

  function automatic logic [79:0] pack_reply(input reply_t r);
    return {r.switch_kind, r.port_selected, r.reply_b10, r.reply_b9, r.reply_b8,
            r.reply_b7, r.reply_b6, r.reply_b5, r.reply_b4, r.reply_src,
            r.reply_dest, r.reply_len};
  endfunction

  function automatic logic [7:0] reply_field(input logic [79:0] w, input int idx);
    int lo;
    lo = 0;
    for (int k = 0; k < idx; k++) lo += FieldWidth[k];
    return 8'((w >> lo) & ((80'd1 << FieldWidth[idx]) - 80'd1));
  endfunction

  function automatic frame_t frm(input logic [7:0] l, input logic [7:0] t,
                                 input logic [7:0] fm, input logic [7:0] c,
                                 input logic [7:0] b5, input logic [7:0] b6);
    return frame_t'{l, t, fm, c, b5, b6};
  endfunction

  // Typed replies are only used while the switch still has its reset state.
  function automatic reply_t rep(input logic [3:0] n, input logic [7:0] d,
                                 input logic [7:0] s, input logic [7:0] b4,
                                 input logic [7:0] b5, input logic [7:0] b6,
                                 input logic [7:0] b7, input logic [7:0] b8,
                                 input logic [7:0] b9, input logic [7:0] b10);
    return reply_t'{n, d, s, b4, b5, b6, b7, b8, b9, b10, 3'd0, 1'b0};
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(input frame_t f, input bit typed, input reply_t want);
    dir_rows.insert(dir_rows.size(), row_t'{f, typed, want});
  endfunction

  // Decides whether a frame is for this switch, builds the reply bytes, and
  // updates the model's type and port the way the switch does.
  function automatic reply_t predict_reply(input frame_t f);
    reply_t     r;
    logic [7:0] b [2:10];
    int         n;
    logic       bc, mine, any, rd6, ok, done;
    logic [7:0] sub, top;
    for (int k = 2; k <= 10; k++) b[k] = 8'h00;
    n = 0;
    if (f.frame_len >= LenMin && !(f.to_addr == model_own && f.from_addr == model_own)) begin
      bc   = (f.to_addr == BcastAddr);
      mine = (f.to_addr == model_own);
      any  = bc || mine;
      rd6  = (f.frame_len == LenRead) && (f.byte_five == CivEnd);
      ok   = mine ||
             (f.command == CmdQuery && f.frame_len >= LenRead && f.byte_five <= 8'd1 && any) ||
             ((f.command == CmdKind || f.command == CmdPort) && rd6 && any);
      if (ok) begin
        sub  = (f.frame_len > LenMin) ? f.byte_five : 8'h00;
        done = 1'b0;
        if (f.command == CmdQuery && sub == SubIpQuery) begin
          n = RepIp;
          b[2] = CivCtrlAddr;    b[3] = model_own;      b[4] = CmdQuery;
          b[5] = SubIpQuery;     b[6] = model_ip[31:24]; b[7] = model_ip[23:16];
          b[8] = model_ip[15:8]; b[9] = model_ip[7:0];   b[10] = CivEnd;
          done = 1'b1;
        end else if (f.command == CmdKind) begin
          if (rd6 && any) begin
            n = RepRead;
            b[2] = f.from_addr; b[3] = model_own; b[4] = CmdKind;
            b[5] = {7'd0, model_kind}; b[6] = CivEnd;
            done = 1'b1;
          end else if (f.frame_len == LenSet && f.byte_five <= 8'd1 &&
                       f.byte_six == CivEnd && mine) begin
            model_kind = f.byte_five[0];
            n = RepRead;
            b[2] = f.from_addr; b[3] = model_own; b[4] = CmdKind;
            b[5] = f.byte_five; b[6] = CivEnd;
            done = 1'b1;
          end else if (bc && f.frame_len == LenSet && f.byte_five <= 8'd1 &&
                       f.byte_six == CivEnd) begin
            n = RepShort;
            b[2] = f.from_addr; b[3] = model_own; b[4] = CivNak; b[5] = CivEnd;
            done = 1'b1;
          end
        end else if (f.command == CmdPort) begin
          if (rd6 && any) begin
            n = RepRead;
            b[2] = f.from_addr; b[3] = model_own; b[4] = CmdPort;
            b[5] = {5'd0, model_port} + 8'd1; b[6] = CivEnd;
            done = 1'b1;
          end else if (f.frame_len == LenSet && f.byte_six == CivEnd && any) begin
            top = model_kind ? TopEight : TopFive;
            if (f.byte_five >= 8'd1 && f.byte_five <= top) begin
              model_port = 3'(f.byte_five - 8'd1);
              n = RepRead;
              b[2] = f.from_addr; b[3] = model_own; b[4] = CmdPort;
              b[5] = f.byte_five; b[6] = CivEnd;
            end else begin
              // Port out of range for the current type: negative reply.
              n = RepShort;
              b[2] = CivCtrlAddr; b[3] = model_own; b[4] = CivNak; b[5] = CivEnd;
            end
            done = 1'b1;
          end
        end
        if (!done) begin
          // Default echo of command and subcommand.
          n = RepEcho;
          b[2] = f.from_addr; b[3] = model_own; b[4] = f.command;
          b[5] = sub;         b[6] = model_own; b[7] = CivEnd;
        end
      end
    end
    r.reply_len     = 4'(n);
    r.reply_dest    = b[2];
    r.reply_src     = b[3];
    r.reply_b4      = b[4];
    r.reply_b5      = b[5];
    r.reply_b6      = b[6];
    r.reply_b7      = b[7];
    r.reply_b8      = b[8];
    r.reply_b9      = b[9];
    r.reply_b10     = b[10];
    r.port_selected = model_port;
    r.switch_kind   = model_kind;
    return r;
  endfunction

  // Random frames. Most are well-formed commands aimed at this switch or at
  // the broadcast address so that type and port actually change; the rest is
  // noise over random fields, half of it with the length held to 0 to 8.
  function automatic frame_t random_frame();
    frame_t     f;
    int         pick;
    f = frm(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
            8'($urandom), 8'($urandom));
    if ($urandom_range(0, 99) < 80) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5 || pick == 9) f.to_addr = model_own;
      else if (pick <= 7) f.to_addr = BcastAddr;
      if ($urandom_range(0, 9) == 0) f.from_addr = model_own;
      f.byte_six = ($urandom_range(0, 9) < 8) ? CivEnd : 8'($urandom);
      pick = $urandom_range(0, 9);
      if (pick <= 2) begin
        f.command   = CmdQuery;
        f.frame_len = 8'($urandom_range(5, 7));
        if ($urandom_range(0, 3) != 0) f.byte_five = 8'($urandom_range(0, 2));
      end else if (pick <= 5) begin
        f.command = CmdKind;
        if ($urandom_range(0, 1) == 0) begin
          f.frame_len = LenRead;
          if ($urandom_range(0, 7) != 0) f.byte_five = CivEnd;
        end else begin
          f.frame_len = LenSet;
          f.byte_five = 8'($urandom_range(0, 3));
        end
      end else if (pick <= 8) begin
        f.command = CmdPort;
        if ($urandom_range(0, 2) == 0) begin
          f.frame_len = LenRead;
          if ($urandom_range(0, 7) != 0) f.byte_five = CivEnd;
        end else begin
          f.frame_len = LenSet;
          f.byte_five = 8'($urandom_range(0, 9));
        end
      end else begin
        f.frame_len = 8'($urandom_range(5, 8));
      end
    end else if ($urandom_range(0, 1) == 0) begin
      f.frame_len = 8'($urandom_range(0, 8));
    end
    return f;
  endfunction

  // Offers one word and waits for the handshake; the expectation is queued at
  // the edge that accepts the word. The sender idles now and then, except in
  // a stretch in the middle of the run.
  task automatic send_frame(input frame_t f, input bit typed, input reply_t want);
    reply_t predicted;
    if (!(frames_sent >= 600 && frames_sent < 800) && $urandom_range(0, 99) < 8) begin
      @(negedge clk);
      s_valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    s_valid <= 1'b1;
    s_data  <= pack_frame(f);
    do @(posedge clk); while (!s_ready);
    predicted = predict_reply(f);
    pending_replies.insert(pending_replies.size(), pack_reply(typed ? want : predicted));
    frames_sent++;
  endtask

  // Stops sending and waits for every queued reply, plus the block's latency.
  task automatic drain_replies();
    @(negedge clk);
    s_valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CfgOwnAddr) model_own = val[7:0];
    else if (idx == CfgIpAddr) model_ip = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Reset is held at the start and released on a falling edge.
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Receiver: takes words with random stalls, holds off for a long stretch
  // every few hundred words so the block backs up into its input, and never
  // stalls in a window in the middle of the run.
  initial begin : receiver
    int next_hold;
    next_hold = HoldEvery;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (results_seen >= next_hold) begin
        next_hold += HoldEvery;
        m_ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
      end else if (results_seen >= 600 && results_seen < 800) begin
        m_ready <= 1'b1;
      end else begin
        m_ready <= ($urandom_range(0, 99) >= 8);
      end
    end
  end

  // Each accepted reply word is compared with the oldest expectation.
  always @(posedge clk) begin : check_replies
    logic [79:0] want;
    if (rst_n && m_valid && m_ready) begin
      results_seen++;
      if (pending_replies.size() == 0) begin
        $display("%0t: reply word %h arrived with none expected", $realtime, m_data);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        for (int k = 0; k < 12; k++) begin
          if (reply_field(want, k) !== reply_field(m_data, k)) begin
            $display("%0t: %s expected %0h actual %0h", $realtime, field_name[k],
                     reply_field(want, k), reply_field(m_data, k));
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: counts cycles in which no handshake of any channel completes.
  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [7:0]  own_set [5];
    logic [31:0] ip_set [5];
    own_set = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), OwnAddrReset};
    ip_set  = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, $urandom, $urandom};

    // Directed frames with the switch in its reset state: address B4, IP 0,
    // five-port type, first port. The first rows carry a typed reply.
    // Too short, zero length included.
    add_row(frm(8'd0, 8'hB4, 8'hE0, CmdQuery, 8'h00, 8'h00), 1'b1, '0);
    add_row(frm(8'd4, 8'hB4, 8'hE0, CmdKind, CivEnd, 8'h00), 1'b1, '0);
    // Own echo: source and destination both equal the own address.
    add_row(frm(8'd6, 8'hB4, 8'hB4, CmdQuery, 8'h00, 8'h00), 1'b1, '0);
    // Addressed to someone else.
    add_row(frm(8'd6, 8'h12, 8'hE0, CmdQuery, 8'h00, 8'h00), 1'b1, '0);
    // Broadcast IP query, type read and port read.
    add_row(frm(8'd6, BcastAddr, 8'hE0, CmdQuery, SubIpQuery, 8'h00), 1'b1,
            rep(RepIp, CivCtrlAddr, 8'hB4, CmdQuery, SubIpQuery,
                8'h00, 8'h00, 8'h00, 8'h00, CivEnd));
    add_row(frm(8'd6, BcastAddr, 8'hE0, CmdKind, CivEnd, 8'h00), 1'b1,
            rep(RepRead, 8'hE0, 8'hB4, CmdKind, 8'h00, CivEnd,
                8'h00, 8'h00, 8'h00, 8'h00));
    add_row(frm(8'd6, BcastAddr, 8'hE0, CmdPort, CivEnd, 8'h00), 1'b1,
            rep(RepRead, 8'hE0, 8'hB4, CmdPort, 8'h01, CivEnd,
                8'h00, 8'h00, 8'h00, 8'h00));
    // Port beyond the five-port range, and port zero: negative reply.
    add_row(frm(8'd7, 8'hB4, 8'hE0, CmdPort, 8'h06, CivEnd), 1'b1,
            rep(RepShort, CivCtrlAddr, 8'hB4, CivNak, CivEnd,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    add_row(frm(8'd7, 8'hB4, 8'hE0, CmdPort, 8'h00, CivEnd), 1'b1,
            rep(RepShort, CivCtrlAddr, 8'hB4, CivNak, CivEnd,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // Five-byte frame: the subcommand reads as zero in the echo.
    add_row(frm(8'd5, 8'hB4, 8'hE0, 8'h55, 8'h77, 8'hFF), 1'b1,
            rep(RepEcho, 8'hE0, 8'hB4, 8'h55, 8'h00, 8'hB4,
                CivEnd, 8'h00, 8'h00, 8'h00));
    // A seven-byte type set sent as broadcast is not for this switch and gets
    // no reply.
    add_row(frm(8'd7, BcastAddr, 8'hE0, CmdKind, 8'h01, CivEnd), 1'b1, '0);
    // From here on the model's state moves, so the predictor decides.
    // Eight-port type, top port, then back to five ports with port 8 kept.
    add_row(frm(8'd7, 8'hB4, 8'hE0, CmdKind, 8'h01, CivEnd), 1'b0, '0);
    add_row(frm(8'd7, 8'hB4, 8'hE0, CmdPort, 8'h08, CivEnd), 1'b0, '0);
    add_row(frm(8'd7, 8'hB4, 8'hE0, CmdKind, 8'h00, CivEnd), 1'b0, '0);
    add_row(frm(8'd6, 8'hB4, 8'hE0, CmdPort, CivEnd, 8'h00), 1'b0, '0);
    add_row(frm(8'd6, 8'hB4, 8'hE0, CmdKind, CivEnd, 8'h00), 1'b0, '0);
    // A seven-byte port set sent as broadcast gets no reply either.
    add_row(frm(8'd7, BcastAddr, 8'hE0, CmdPort, 8'h03, CivEnd), 1'b0, '0);
    // Broadcast address query gets the echo; a broadcast 19 02 is ignored.
    add_row(frm(8'd6, BcastAddr, 8'hE0, CmdQuery, 8'h00, 8'h00), 1'b0, '0);
    add_row(frm(8'd6, BcastAddr, 8'hE0, CmdQuery, 8'h02, 8'h00), 1'b0, '0);
    // Maximum length with all-ones bytes, an invalid type value, an unknown
    // destination with a zero source, a direct IP query and the top port of
    // the five-port type.
    add_row(frm(8'd255, 8'hB4, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0, '0);
    add_row(frm(8'd7, 8'hB4, 8'hE0, CmdKind, 8'h02, CivEnd), 1'b0, '0);
    add_row(frm(8'd6, 8'hFF, 8'h00, CmdPort, CivEnd, 8'h00), 1'b0, '0);
    add_row(frm(8'd6, 8'hB4, 8'hE0, CmdQuery, SubIpQuery, 8'h00), 1'b0, '0);
    add_row(frm(8'd7, 8'hB4, 8'hE0, CmdPort, 8'h05, CivEnd), 1'b0, '0);

    wait (rst_n);
    foreach (dir_rows[i]) send_frame(dir_rows[i].f, dir_rows[i].typed, dir_rows[i].want);
    drain_replies();

    // Random phases, each under its own address settings. Address zero makes
    // every broadcast frame look addressed to the switch as well.
    for (int p = 0; p < 5; p++) begin
      write_reg(CfgOwnAddr, {24'd0, own_set[p]});
      write_reg(CfgIpAddr, ip_set[p]);
      for (int i = 0; i < PhaseItems; i++) send_frame(random_frame(), 1'b0, '0);
      drain_replies();
    end

    repeat (6) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/civ_asr_pkg.sv
sv/civ_antenna_switch_responder.sv
bench/tb_civ_antenna_switch_responder.sv
